### sv/cff_dict_token_decoder_macros.svh
// Assertion macros used by the font dictionary parser module.
`ifndef CFF_DICT_TOKEN_DECODER_MACROS_SVH
`define CFF_DICT_TOKEN_DECODER_MACROS_SVH

`ifndef SYNTHESIS

`define CFFDTD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define CFFDTD_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define CFFDTD_ASSERT_IMP(label, ante, cons, msg)

`define CFFDTD_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

### sv/cffdtd_pkg.sv
// Types and constants of the font dictionary token decoder.
package cffdtd_pkg;

   localparam int MAX_OPERANDS = 48;
   localparam int DEPTH_W      = $clog2(MAX_OPERANDS + 1);

   localparam logic [7:0] OP_ESCAPE      = 8'd12;
   localparam logic [7:0] OP_LIMIT       = 8'd22;
   localparam logic [7:0] LEAD_SHORT_INT = 8'd28;
   localparam logic [7:0] LEAD_LONG_INT  = 8'd29;
   localparam logic [7:0] LEAD_REAL      = 8'd30;
   localparam logic [7:0] SMALL_LOW      = 8'd32;
   localparam logic [7:0] SMALL_HIGH     = 8'd246;
   localparam logic [7:0] POS_LOW        = 8'd247;
   localparam logic [7:0] NEG_LOW        = 8'd251;
   localparam logic [7:0] NEG_HIGH       = 8'd254;
   localparam logic [31:0] BIAS_SMALL    = 32'd139;
   localparam logic [31:0] BIAS_MEDIUM   = 32'd108;
   localparam logic [5:0]  COUNT_MAX     = 6'd63;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_TRUNC_OPERAND = 3'd1,
      ST_TRUNC_ESCAPE  = 3'd2,
      ST_BAD_LEAD      = 3'd3,
      ST_OVERFLOW      = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_dict;
   } req_item_type;

   typedef struct packed {
      logic [8:0]         operator_code;
      logic signed [31:0] first_operand;
      logic signed [31:0] second_operand;
      logic [5:0]         operand_count;
      logic [1:0]         real_flags;
      logic [2:0]         status;
   } rsp_item_type;

endpackage

### sv/cff_dict_token_decoder.sv
// Top level of the font dictionary token decoder: input and result registers around the parser.
//
// The decoder takes one dictionary byte per transfer and sustains one byte per clock cycle
// while the result side does not stall. A byte enters the input register at its transfer,
// the parser decodes it from there, and any result it causes is written to the result
// register when the byte moves on, and is offered from the result register.
// Bytes that only build operands give no result. After an error result the block
// drops bytes until the end mark, and every end mark returns the parser and its operand
// summary to the reset state. The input side stalls while the input register holds a byte
// and the result register is full and stalled, whether or not that byte would produce a
// result.
module cff_dict_token_decoder (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  cffdtd_pkg::req_item_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output cffdtd_pkg::rsp_item_type rsp_data
);
   import cffdtd_pkg::*;

   logic         in_vld_ff, in_vld_in;
   req_item_type in_data_ff;
   logic         rsp_vld_ff, rsp_vld_in;
   rsp_item_type rsp_data_ff;

   logic         advance;
   logic         load_in;
   logic         res_vld;
   rsp_item_type res;

   // The held byte moves on whenever the result register is free or being emptied.
   assign advance   = in_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign load_in   = !in_vld_ff || advance;
   assign req_stall = !load_in;

   assign in_vld_in = load_in ? req_valid : in_vld_ff;

   always_comb begin
      if (advance) begin
         rsp_vld_in = res_vld;
      end else if (rsp_vld_ff && !rsp_stall) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   cffdtd_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .item    (in_data_ff),
      .res_vld (res_vld),
      .res     (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_in && req_valid) begin
         in_data_ff <= req_data;
      end
      if (advance && res_vld) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### sv/cffdtd_parse.sv
// Byte parser: operand decoding, operand stack summary and operator results.
`include "cff_dict_token_decoder_macros.svh"

module cffdtd_parse (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  cffdtd_pkg::req_item_type item,
   output logic                     res_vld,
   output cffdtd_pkg::rsp_item_type res
);
   import cffdtd_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_INT,
      PH_REAL,
      PH_ESC,
      PH_DISCARD
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [7:0]         lead_ff, lead_in;
   logic [2:0]         pend_ff, pend_in;
   logic [31:0]        acc_ff, acc_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [31:0]        first_ff, first_in;
   logic [31:0]        second_ff, second_in;
   logic [1:0]         flags_ff, flags_in;

   logic [7:0]  b;
   logic        eod;
   status_type  err;
   logic        op_emit;
   logic [8:0]  op_code;
   logic        push_req;
   logic        push_real;
   logic [31:0] push_val;
   logic [31:0] acc_shift;
   logic [2:0]  pend_dec;
   logic [7:0]  med_off;
   logic [31:0] med_mag;
   logic [31:0] int_value;
   logic [31:0] cnt_wide;

   assign b         = item.data_byte;
   assign eod       = item.end_of_dict;
   assign acc_shift = {acc_ff[23:0], b};

   // Value of a completed multi-byte integer; the last byte is the current one.
   always_comb begin
      med_off = (lead_ff < NEG_LOW) ? (lead_ff - POS_LOW) : (lead_ff - NEG_LOW);
      med_mag = {22'b0, med_off[1:0], b} + BIAS_MEDIUM;
      case (lead_ff)
         LEAD_SHORT_INT: int_value = {{16{acc_shift[15]}}, acc_shift[15:0]};
         LEAD_LONG_INT:  int_value = acc_shift;
         default:        int_value = (lead_ff < NEG_LOW) ? med_mag : (32'd0 - med_mag);
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      lead_in   = lead_ff;
      pend_in   = pend_ff;
      acc_in    = acc_ff;
      depth_in  = depth_ff;
      first_in  = first_ff;
      second_in = second_ff;
      flags_in  = flags_ff;
      err       = ST_OK;
      op_emit   = 1'b0;
      op_code   = '0;
      push_req  = 1'b0;
      push_real = 1'b0;
      push_val  = '0;
      pend_dec  = (pend_ff != 3'd0) ? (pend_ff - 3'd1) : 3'd0;

      case (phase_ff)
         PH_IDLE: begin
            if (b < OP_LIMIT) begin
               if (b == OP_ESCAPE) begin
                  if (eod) begin
                     err = ST_TRUNC_ESCAPE;
                  end else begin
                     phase_in = PH_ESC;
                  end
               end else begin
                  op_emit = 1'b1;
                  op_code = {1'b0, b};
               end
            end else if (b inside {[SMALL_LOW:SMALL_HIGH]}) begin
               push_req = 1'b1;
               push_val = {24'b0, b} - BIAS_SMALL;
            end else if (b == LEAD_SHORT_INT || b == LEAD_LONG_INT ||
                         b inside {[POS_LOW:NEG_HIGH]}) begin
               lead_in = b;
               acc_in  = '0;
               if (b == LEAD_SHORT_INT) begin
                  pend_in = 3'd2;
               end else if (b == LEAD_LONG_INT) begin
                  pend_in = 3'd4;
               end else begin
                  pend_in = 3'd1;
               end
               if (eod) begin
                  err = ST_TRUNC_OPERAND;
               end else begin
                  phase_in = PH_INT;
               end
            end else if (b == LEAD_REAL) begin
               lead_in  = b;
               phase_in = PH_REAL;
            end else begin
               err = ST_BAD_LEAD;
            end
         end
         PH_INT: begin
            acc_in  = acc_shift;
            pend_in = pend_dec;
            if (pend_dec == 3'd0) begin
               phase_in = PH_IDLE;
               push_req = 1'b1;
               push_val = int_value;
            end else if (eod) begin
               err = ST_TRUNC_OPERAND;
            end
         end
         PH_REAL: begin
            // A real ends with the first byte that holds an all-ones nibble.
            if (b[7:4] == 4'hF || b[3:0] == 4'hF) begin
               phase_in  = PH_IDLE;
               push_req  = 1'b1;
               push_real = 1'b1;
            end
         end
         PH_ESC: begin
            op_emit  = 1'b1;
            op_code  = {1'b1, b};
            phase_in = PH_IDLE;
         end
         PH_DISCARD: begin
         end
         default: begin
         end
      endcase

      // Only the first two operands are kept; deeper ones are only counted.
      if (push_req) begin
         if (depth_ff >= DEPTH_W'(MAX_OPERANDS)) begin
            err = ST_OVERFLOW;
         end else begin
            if (depth_ff == '0) begin
               first_in    = push_real ? 32'd0 : push_val;
               flags_in[0] = flags_ff[0] | push_real;
            end else if (depth_ff == DEPTH_W'(1)) begin
               second_in   = push_real ? 32'd0 : push_val;
               flags_in[1] = flags_ff[1] | push_real;
            end
            depth_in = depth_ff + DEPTH_W'(1);
         end
      end

      if (op_emit) begin
         depth_in  = '0;
         first_in  = '0;
         second_in = '0;
         flags_in  = '0;
      end

      if (err != ST_OK) begin
         phase_in = PH_DISCARD;
      end

      if (eod) begin
         phase_in  = PH_IDLE;
         lead_in   = '0;
         pend_in   = '0;
         acc_in    = '0;
         depth_in  = '0;
         first_in  = '0;
         second_in = '0;
         flags_in  = '0;
      end
   end

   // Results carry the operand summary as it stood before this byte.
   always_comb begin
      cnt_wide           = 32'(depth_ff);
      res_vld            = op_emit || (err != ST_OK);
      res.operator_code  = (err != ST_OK) ? 9'd0 : op_code;
      res.first_operand  = first_ff;
      res.second_operand = second_ff;
      res.operand_count  = (cnt_wide > 32'(COUNT_MAX)) ? COUNT_MAX : cnt_wide[5:0];
      res.real_flags     = flags_ff;
      res.status         = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         lead_ff   <= '0;
         pend_ff   <= '0;
         acc_ff    <= '0;
         depth_ff  <= '0;
         first_ff  <= '0;
         second_ff <= '0;
         flags_ff  <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         lead_ff   <= lead_in;
         pend_ff   <= pend_in;
         acc_ff    <= acc_in;
         depth_ff  <= depth_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         flags_ff  <= flags_in;
      end
   end

   `CFFDTD_ASSERT_IMP(a_depth_bound, 1'b1, depth_ff <= DEPTH_W'(MAX_OPERANDS), "operand depth beyond limit")
   `CFFDTD_ASSERT_NXT(a_end_clears, step && eod, (phase_ff == PH_IDLE) && (depth_ff == '0), "end mark did not clear state")
   `CFFDTD_ASSERT_IMP(a_discard_silent, step && (phase_ff == PH_DISCARD), !res_vld, "result while discarding")
   `CFFDTD_ASSERT_IMP(a_int_pending, phase_ff == PH_INT, pend_ff != 3'd0, "integer phase with no bytes pending")

endmodule
